/* sv/vad_pkg.sv */
`default_nettype none
package vad_pkg;

	localparam int unsigned QueueDepth = 2;

	typedef enum logic [2:0] {
		COL_NONE = 3'd0,
		COL_8888 = 3'd1,
		COL_4444 = 3'd2,
		COL_565  = 3'd3,
		COL_5551 = 3'd4
	} col_fmt_e;

	localparam logic [2:0] TEX_NONE = 3'd0;
	localparam logic [2:0] TEX_U8 = 3'd1;
	localparam logic [2:0] TEX_U16 = 3'd2;
	localparam logic [2:0] TEX_FLT = 3'd3;
	localparam logic [2:0] TEX_U16T = 3'd4;
	localparam logic [2:0] TEX_FLTT = 3'd5;

	localparam logic [1:0] NRM_NONE = 2'd0;
	localparam logic [1:0] NRM_S8 = 2'd1;
	localparam logic [1:0] NRM_S16 = 2'd2;
	localparam logic [1:0] NRM_FLT = 2'd3;

	localparam logic [2:0] POS_S8 = 3'd0;
	localparam logic [2:0] POS_S16 = 3'd1;
	localparam logic [2:0] POS_FLT = 3'd2;
	localparam logic [2:0] POS_S8T = 3'd3;
	localparam logic [2:0] POS_S16T = 3'd4;
	localparam logic [2:0] POS_FLTT = 3'd5;

	localparam logic [2:0] REG_COLOR = 3'd0;
	localparam logic [2:0] REG_TEX = 3'd1;
	localparam logic [2:0] REG_NORMAL = 3'd2;
	localparam logic [2:0] REG_POS = 3'd3;
	localparam logic [2:0] REG_MIN_U = 3'd4;
	localparam logic [2:0] REG_MAX_U = 3'd5;
	localparam logic [2:0] REG_MIN_V = 3'd6;
	localparam logic [2:0] REG_MAX_V = 3'd7;

	localparam logic [31:0] FLT_Z_LIMIT = 32'h477fff00;

	typedef struct packed {
		logic        first_of_batch;
		logic [31:0] raw_color;
		logic [31:0] raw_u;
		logic [31:0] raw_v;
		logic [31:0] raw_nx;
		logic [31:0] raw_ny;
		logic [31:0] raw_nz;
		logic [31:0] raw_px;
		logic [31:0] raw_py;
		logic [31:0] raw_pz;
	} vin_t;

	typedef struct packed {
		logic [31:0] color_rgba;
		logic [31:0] tex_u;
		logic [31:0] tex_v;
		logic [31:0] normal_x;
		logic [31:0] normal_y;
		logic [31:0] normal_z;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic        all_alpha_full;
		logic [63:0] uv_bounds;
	} vout_t;

	// item after classification: stateful parts resolved, float work left
	typedef struct packed {
		logic [31:0] color_rgba;
		logic        all_alpha_full;
		logic [63:0] uv_bounds;
		logic [2:0]  tex_fmt;
		logic [1:0]  nrm_fmt;
		logic [2:0]  pos_fmt;
		logic [31:0] raw_u;
		logic [31:0] raw_v;
		logic [31:0] raw_nx;
		logic [31:0] raw_ny;
		logic [31:0] raw_nz;
		logic [31:0] raw_px;
		logic [31:0] raw_py;
		logic [31:0] raw_pz;
	} vmid_t;

	typedef struct packed {
		logic [2:0] color_format;
		logic [2:0] texcoord_format;
		logic [1:0] normal_format;
		logic [2:0] position_format;
		logic [15:0] start_min_u;
		logic [15:0] start_max_u;
		logic [15:0] start_min_v;
		logic [15:0] start_max_v;
	} cfg_t;

	function automatic logic [7:0] rep5(input logic [4:0] x);
		return {x, x[4:2]};
	endfunction

	// exact int to float for magnitudes below 2^16, then scaled by 2^-sh
	function automatic logic [31:0] i2f(input logic neg, input logic [15:0] mag,
			input logic [4:0] sh);
		logic [4:0] lz;
		logic [15:0] nm;
		logic [7:0] ex;
		lz = 5'd16;
		for (int i = 0; i < 16; i++) begin
			if (mag[i]) lz = 5'(15 - i);
		end
		nm = mag << lz;
		ex = 8'(8'd142 - {3'd0, lz} - {3'd0, sh});
		if (mag == 16'd0) return 32'd0;
		return {neg, ex, nm[14:0], 8'd0};
	endfunction

	function automatic logic [31:0] s2f(input logic [15:0] v, input logic [4:0] sh);
		logic [15:0] m;
		m = v[15] ? 16'(-v) : v;
		return i2f(v[15], m, sh);
	endfunction

endpackage
`default_nettype wire

/* sv/vad_if.sv */
`default_nettype none
interface vad_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/vad_front.sv */
`default_nettype none
module vad_front (
	input  wire              clk,
	input  wire              arst_n,
	input  vad_pkg::cfg_t    cfg,
	input  wire              in_valid,
	output logic             in_ready,
	input  vad_pkg::vin_t    in_data,
	output logic             mid_valid,
	input  wire              mid_ready,
	output vad_pkg::vmid_t   mid_data
);
	logic        alpha_q;
	logic [15:0] min_u_q, max_u_q, min_v_q, max_v_q;
	logic        a0, a1;
	logic [15:0] mu0, xu0, mv0, xv0, mu1, xu1, mv1, xv1, u16, v16;
	logic [31:0] c, col;
	logic        take;

	assign in_ready = mid_ready;
	assign take = in_valid && mid_ready;
	assign c = in_data.raw_color;
	assign u16 = in_data.raw_u[15:0];
	assign v16 = in_data.raw_v[15:0];

	// batch reload, then color expand and alpha/bound update
	always_comb begin
		a0 = in_data.first_of_batch ? 1'b1 : alpha_q;
		mu0 = in_data.first_of_batch ? cfg.start_min_u : min_u_q;
		xu0 = in_data.first_of_batch ? cfg.start_max_u : max_u_q;
		mv0 = in_data.first_of_batch ? cfg.start_min_v : min_v_q;
		xv0 = in_data.first_of_batch ? cfg.start_max_v : max_v_q;
		a1 = a0;
		case (cfg.color_format)
			vad_pkg::COL_8888: begin
				col = c;
				if (c[31:24] != 8'hff) a1 = 1'b0;
			end
			vad_pkg::COL_4444: begin
				col = {{2{c[15:12]}}, {2{c[11:8]}}, {2{c[7:4]}}, {2{c[3:0]}}};
				if (c[15:12] != 4'hf) a1 = 1'b0;
			end
			vad_pkg::COL_565: col = {8'hff, vad_pkg::rep5(c[15:11]),
				c[10:5], c[10:9], vad_pkg::rep5(c[4:0])};
			vad_pkg::COL_5551: begin
				col = {{8{c[15]}}, vad_pkg::rep5(c[14:10]), vad_pkg::rep5(c[9:5]),
					vad_pkg::rep5(c[4:0])};
				if (!c[15]) a1 = 1'b0;
			end
			default: col = 32'd0;
		endcase
		mu1 = mu0; xu1 = xu0; mv1 = mv0; xv1 = xv0;
		if (cfg.texcoord_format == vad_pkg::TEX_U16T) begin
			if (u16 < mu0) mu1 = u16;
			if (u16 > xu0) xu1 = u16;
			if (v16 < mv0) mv1 = v16;
			if (v16 > xv0) xv1 = v16;
		end
	end

	always_comb begin
		mid_valid = in_valid;
		mid_data.color_rgba = col;
		mid_data.all_alpha_full = a1;
		mid_data.uv_bounds = {xv1, mv1, xu1, mu1};
		mid_data.tex_fmt = cfg.texcoord_format;
		mid_data.nrm_fmt = cfg.normal_format;
		mid_data.pos_fmt = cfg.position_format;
		mid_data.raw_u = in_data.raw_u;
		mid_data.raw_v = in_data.raw_v;
		mid_data.raw_nx = in_data.raw_nx;
		mid_data.raw_ny = in_data.raw_ny;
		mid_data.raw_nz = in_data.raw_nz;
		mid_data.raw_px = in_data.raw_px;
		mid_data.raw_py = in_data.raw_py;
		mid_data.raw_pz = in_data.raw_pz;
	end

	// running state advances per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 1'b1;
			min_u_q <= 16'hffff;
			max_u_q <= 16'd0;
			min_v_q <= 16'hffff;
			max_v_q <= 16'd0;
		end else if (take) begin
			alpha_q <= a1;
			min_u_q <= mu1;
			max_u_q <= xu1;
			min_v_q <= mv1;
			max_v_q <= xv1;
		end
	end
endmodule
`default_nettype wire

/* sv/vad_queue.sv */
`default_nettype none
module vad_queue #(
	parameter int unsigned Depth = vad_pkg::QueueDepth
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             wr_valid,
	output logic            wr_ready,
	input  vad_pkg::vmid_t  wr_data,
	output logic            rd_valid,
	input  wire             rd_ready,
	output vad_pkg::vmid_t  rd_data
);
	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
	vad_pkg::vmid_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(Depth);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	// pointers wrap at depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
endmodule
`default_nettype wire

/* sv/vad_back.sv */
`default_nettype none
module vad_back (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             mid_valid,
	output logic            mid_ready,
	input  vad_pkg::vmid_t  mid_data,
	output logic            out_valid,
	input  wire             out_ready,
	output vad_pkg::vout_t  out_data
);
	vad_pkg::vout_t r;
	vad_pkg::vout_t out_s1;
	logic valid_s1;
	logic [31:0] z;

	assign mid_ready = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data = out_s1;
	assign z = mid_data.raw_pz;

	// per-field float conversions
	always_comb begin
		r = '0;
		r.color_rgba = mid_data.color_rgba;
		r.all_alpha_full = mid_data.all_alpha_full;
		r.uv_bounds = mid_data.uv_bounds;
		case (mid_data.tex_fmt)
			vad_pkg::TEX_U8: begin
				r.tex_u = vad_pkg::i2f(1'b0, {8'd0, mid_data.raw_u[7:0]}, 5'd7);
				r.tex_v = vad_pkg::i2f(1'b0, {8'd0, mid_data.raw_v[7:0]}, 5'd7);
			end
			vad_pkg::TEX_U16: begin
				r.tex_u = vad_pkg::i2f(1'b0, mid_data.raw_u[15:0], 5'd15);
				r.tex_v = vad_pkg::i2f(1'b0, mid_data.raw_v[15:0], 5'd15);
			end
			vad_pkg::TEX_FLT, vad_pkg::TEX_FLTT: begin
				r.tex_u = mid_data.raw_u;
				r.tex_v = mid_data.raw_v;
			end
			vad_pkg::TEX_U16T: begin
				r.tex_u = vad_pkg::i2f(1'b0, mid_data.raw_u[15:0], 5'd0);
				r.tex_v = vad_pkg::i2f(1'b0, mid_data.raw_v[15:0], 5'd0);
			end
			default: ;
		endcase
		case (mid_data.nrm_fmt)
			vad_pkg::NRM_S8: begin
				r.normal_x = {24'd0, mid_data.raw_nx[7:0]};
				r.normal_y = {24'd0, mid_data.raw_ny[7:0]};
				r.normal_z = {24'd0, mid_data.raw_nz[7:0]};
			end
			vad_pkg::NRM_S16: begin
				r.normal_x = {16'd0, mid_data.raw_nx[15:0]};
				r.normal_y = {16'd0, mid_data.raw_ny[15:0]};
				r.normal_z = {16'd0, mid_data.raw_nz[15:0]};
			end
			vad_pkg::NRM_FLT: begin
				r.normal_x = mid_data.raw_nx;
				r.normal_y = mid_data.raw_ny;
				r.normal_z = mid_data.raw_nz;
			end
			default: ;
		endcase
		case (mid_data.pos_fmt)
			vad_pkg::POS_S8: begin
				r.pos_x = vad_pkg::s2f({{8{mid_data.raw_px[7]}}, mid_data.raw_px[7:0]}, 5'd7);
				r.pos_y = vad_pkg::s2f({{8{mid_data.raw_py[7]}}, mid_data.raw_py[7:0]}, 5'd7);
				r.pos_z = vad_pkg::s2f({{8{z[7]}}, z[7:0]}, 5'd7);
			end
			vad_pkg::POS_S16: begin
				r.pos_x = vad_pkg::s2f(mid_data.raw_px[15:0], 5'd15);
				r.pos_y = vad_pkg::s2f(mid_data.raw_py[15:0], 5'd15);
				r.pos_z = vad_pkg::s2f(z[15:0], 5'd15);
			end
			vad_pkg::POS_FLT: begin
				r.pos_x = mid_data.raw_px;
				r.pos_y = mid_data.raw_py;
				r.pos_z = z;
			end
			vad_pkg::POS_S16T: begin
				r.pos_x = vad_pkg::s2f(mid_data.raw_px[15:0], 5'd0);
				r.pos_y = vad_pkg::s2f(mid_data.raw_py[15:0], 5'd0);
				r.pos_z = vad_pkg::i2f(1'b0, z[15:0], 5'd0);
			end
			vad_pkg::POS_FLTT: begin
				r.pos_x = mid_data.raw_px;
				r.pos_y = mid_data.raw_py;
				// nan, zero and negatives to +0, large values to the limit
				if (z[31] || z[30:0] == 31'd0 || z[30:0] > 31'h7f800000) r.pos_z = 32'd0;
				else if (z[30:0] > vad_pkg::FLT_Z_LIMIT[30:0]) r.pos_z = vad_pkg::FLT_Z_LIMIT;
				else r.pos_z = z;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (mid_ready) valid_s1 <= mid_valid;
	end

	always_ff @(posedge clk) begin
		if (mid_ready && mid_valid) out_s1 <= r;
	end
endmodule
`default_nettype wire

/* sv/vertex_attribute_decoder.sv */
`default_nettype none
// channel | dir | payload
// vin     | in  | first_of_batch, raw_color, raw_u/v, raw_nx/ny/nz, raw_px/py/pz
// vout    | out | color_rgba, tex_u/v, normal_x/y/z, pos_x/y/z, all_alpha_full, uv_bounds
// cfg     | in  | cfg_we, cfg_index[2:0], cfg_data[15:0]
// one item per cycle while vout is ready; passes a queue entry, then the output register
// front updates alpha flag and uv bounds on accept; back does float conversion
// reset gives the register reset values and an empty queue
// input stalls only when the queue is full
module vertex_attribute_decoder #(
	parameter int unsigned QueueDepth = vad_pkg::QueueDepth
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire [2:0]  cfg_index,
	input  wire [15:0] cfg_data,
	vad_if.sink        vin,
	vad_if.source      vout
);
	vad_pkg::cfg_t cfg_q;
	logic mv, mr, qv, qr;
	vad_pkg::vmid_t md, qd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_format <= vad_pkg::COL_NONE;
			cfg_q.texcoord_format <= vad_pkg::TEX_NONE;
			cfg_q.normal_format <= vad_pkg::NRM_NONE;
			cfg_q.position_format <= vad_pkg::POS_FLT;
			cfg_q.start_min_u <= 16'hffff;
			cfg_q.start_max_u <= 16'd0;
			cfg_q.start_min_v <= 16'hffff;
			cfg_q.start_max_v <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				vad_pkg::REG_COLOR: cfg_q.color_format <= cfg_data[2:0];
				vad_pkg::REG_TEX: cfg_q.texcoord_format <= cfg_data[2:0];
				vad_pkg::REG_NORMAL: cfg_q.normal_format <= cfg_data[1:0];
				vad_pkg::REG_POS: cfg_q.position_format <= cfg_data[2:0];
				vad_pkg::REG_MIN_U: cfg_q.start_min_u <= cfg_data;
				vad_pkg::REG_MAX_U: cfg_q.start_max_u <= cfg_data;
				vad_pkg::REG_MIN_V: cfg_q.start_min_v <= cfg_data;
				vad_pkg::REG_MAX_V: cfg_q.start_max_v <= cfg_data;
				default: ;
			endcase
		end
	end

	vad_front u_front (.clk, .arst_n, .cfg(cfg_q), .in_valid(vin.valid),
		.in_ready(vin.ready), .in_data(vin.data), .mid_valid(mv),
		.mid_ready(mr), .mid_data(md));

	vad_queue #(.Depth(QueueDepth)) u_queue (.clk, .arst_n, .wr_valid(mv),
		.wr_ready(mr), .wr_data(md), .rd_valid(qv), .rd_ready(qr), .rd_data(qd));

	vad_back u_back (.clk, .arst_n, .mid_valid(qv), .mid_ready(qr), .mid_data(qd),
		.out_valid(vout.valid), .out_ready(vout.ready), .out_data(vout.data));

	// a stalled result must hold
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vout.valid && !vout.ready |=> vout.valid && $stable(vout.data))
		else $error("result changed under stall");
	// alpha flag set on a batch start in the 565 color format, which has no alpha
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		vin.valid && vin.ready && vin.data.first_of_batch &&
		cfg_q.color_format == vad_pkg::COL_565 |-> md.all_alpha_full)
		else $error("alpha flag not set at batch start");
	// empty queue means input can be taken
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!qv |-> vin.ready)
		else $error("input stalled with empty queue");
endmodule
`default_nettype wire

/* tb/sv/vertex_attribute_decoder_tb.sv */
`default_nettype none
module vertex_attribute_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RandomItems = 1950;
	localparam longint unsigned CycleLimit = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	vad_if #(.T(vad_pkg::vin_t)) vin ();
	vad_if #(.T(vad_pkg::vout_t)) vout ();

	vertex_attribute_decoder dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .vin(vin.sink), .vout(vout.source)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor copy of configuration and state
	vad_pkg::cfg_t shadow_cfg;
	logic alpha_full;
	logic [15:0] lo_u, hi_u, lo_v, hi_v;
	vad_pkg::vout_t pending_vertices[$];
	int unsigned mismatches = 0;
	bit timed_out = 1'b0;
	longint unsigned cycle_count = 0;
	bit hold_sink = 1'b0;
	bit hold_go = 1'b0;

	// int to float bits, exact for |v| < 2^16, scaled by 2^-sh
	function automatic logic [31:0] int_to_float(input int v, input int sh);
		logic [31:0] mag;
		logic sgn;
		int msb;
		logic [31:0] man;
		sgn = v < 0;
		mag = sgn ? -v : v;
		if (mag == 0) return 32'd0;
		msb = 0;
		for (int i = 0; i < 32; i++) if (mag[i]) msb = i;
		man = mag << (23 - msb);
		return {sgn, 8'(127 + msb - sh), man[22:0]};
	endfunction

	function automatic int sext8(input logic [31:0] v);
		return int'($signed(v[7:0]));
	endfunction

	function automatic int sext16(input logic [31:0] v);
		return int'($signed(v[15:0]));
	endfunction

	function automatic logic [7:0] widen5(input logic [4:0] x);
		return {x, x[4:2]};
	endfunction

	// clamp of float through z
	function automatic logic [31:0] clamp_z(input logic [31:0] b);
		if (b[30:23] == 8'hff && b[22:0] != 0) return 32'd0;
		if (b[31] || b == 32'd0) return 32'd0;
		if (b > vad_pkg::FLT_Z_LIMIT) return vad_pkg::FLT_Z_LIMIT;
		return b;
	endfunction

	function automatic vad_pkg::vout_t decode_vertex(input vad_pkg::vin_t v);
		vad_pkg::vout_t r;
		logic [15:0] cu, cv;
		r = '0;
		if (v.first_of_batch) begin
			lo_u = shadow_cfg.start_min_u; hi_u = shadow_cfg.start_max_u;
			lo_v = shadow_cfg.start_min_v; hi_v = shadow_cfg.start_max_v;
			alpha_full = 1'b1;
		end
		// color expansion
		case (shadow_cfg.color_format)
			vad_pkg::COL_8888: begin
				if (v.raw_color[31:24] != 8'hff) alpha_full = 1'b0;
				r.color_rgba = v.raw_color;
			end
			vad_pkg::COL_4444: begin
				if (v.raw_color[15:12] != 4'hf) alpha_full = 1'b0;
				r.color_rgba = {{2{v.raw_color[15:12]}}, {2{v.raw_color[11:8]}},
					{2{v.raw_color[7:4]}}, {2{v.raw_color[3:0]}}};
			end
			vad_pkg::COL_565: r.color_rgba = {8'hff, widen5(v.raw_color[15:11]),
				v.raw_color[10:5], v.raw_color[10:9], widen5(v.raw_color[4:0])};
			vad_pkg::COL_5551: begin
				if (!v.raw_color[15]) alpha_full = 1'b0;
				r.color_rgba = {{8{v.raw_color[15]}}, widen5(v.raw_color[14:10]),
					widen5(v.raw_color[9:5]), widen5(v.raw_color[4:0])};
			end
			default: r.color_rgba = '0;
		endcase
		// texture coordinates
		case (shadow_cfg.texcoord_format)
			vad_pkg::TEX_U8: begin
				r.tex_u = int_to_float(int'(v.raw_u[7:0]), 7);
				r.tex_v = int_to_float(int'(v.raw_v[7:0]), 7);
			end
			vad_pkg::TEX_U16: begin
				r.tex_u = int_to_float(int'(v.raw_u[15:0]), 15);
				r.tex_v = int_to_float(int'(v.raw_v[15:0]), 15);
			end
			vad_pkg::TEX_FLT, vad_pkg::TEX_FLTT: begin
				r.tex_u = v.raw_u;
				r.tex_v = v.raw_v;
			end
			vad_pkg::TEX_U16T: begin
				cu = v.raw_u[15:0];
				cv = v.raw_v[15:0];
				if (cu < lo_u) lo_u = cu;
				if (cu > hi_u) hi_u = cu;
				if (cv < lo_v) lo_v = cv;
				if (cv > hi_v) hi_v = cv;
				r.tex_u = int_to_float(int'(cu), 0);
				r.tex_v = int_to_float(int'(cv), 0);
			end
			default: ;
		endcase
		// normals
		case (shadow_cfg.normal_format)
			vad_pkg::NRM_S8: begin
				r.normal_x = {24'd0, v.raw_nx[7:0]}; r.normal_y = {24'd0, v.raw_ny[7:0]};
				r.normal_z = {24'd0, v.raw_nz[7:0]};
			end
			vad_pkg::NRM_S16: begin
				r.normal_x = {16'd0, v.raw_nx[15:0]}; r.normal_y = {16'd0, v.raw_ny[15:0]};
				r.normal_z = {16'd0, v.raw_nz[15:0]};
			end
			vad_pkg::NRM_FLT: begin
				r.normal_x = v.raw_nx; r.normal_y = v.raw_ny; r.normal_z = v.raw_nz;
			end
			default: ;
		endcase
		// positions
		case (shadow_cfg.position_format)
			vad_pkg::POS_S8: begin
				r.pos_x = int_to_float(sext8(v.raw_px), 7);
				r.pos_y = int_to_float(sext8(v.raw_py), 7);
				r.pos_z = int_to_float(sext8(v.raw_pz), 7);
			end
			vad_pkg::POS_S16: begin
				r.pos_x = int_to_float(sext16(v.raw_px), 15);
				r.pos_y = int_to_float(sext16(v.raw_py), 15);
				r.pos_z = int_to_float(sext16(v.raw_pz), 15);
			end
			vad_pkg::POS_FLT: begin
				r.pos_x = v.raw_px; r.pos_y = v.raw_py; r.pos_z = v.raw_pz;
			end
			vad_pkg::POS_S16T: begin
				r.pos_x = int_to_float(sext16(v.raw_px), 0);
				r.pos_y = int_to_float(sext16(v.raw_py), 0);
				r.pos_z = int_to_float(int'(v.raw_pz[15:0]), 0);
			end
			vad_pkg::POS_FLTT: begin
				r.pos_x = v.raw_px; r.pos_y = v.raw_py;
				r.pos_z = clamp_z(v.raw_pz);
			end
			default: ;
		endcase
		r.all_alpha_full = alpha_full;
		r.uv_bounds = {hi_v, lo_v, hi_u, lo_u};
		return r;
	endfunction

	// register write, mirrored in the predictor
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			vad_pkg::REG_COLOR: shadow_cfg.color_format = val[2:0];
			vad_pkg::REG_TEX: shadow_cfg.texcoord_format = val[2:0];
			vad_pkg::REG_NORMAL: shadow_cfg.normal_format = val[1:0];
			vad_pkg::REG_POS: shadow_cfg.position_format = val[2:0];
			vad_pkg::REG_MIN_U: shadow_cfg.start_min_u = val;
			vad_pkg::REG_MAX_U: shadow_cfg.start_max_u = val;
			vad_pkg::REG_MIN_V: shadow_cfg.start_min_v = val;
			default: shadow_cfg.start_max_v = val;
		endcase
	endtask

	task automatic write_formats(input logic [2:0] c, input logic [2:0] t,
			input logic [1:0] n, input logic [2:0] p);
		write_reg(vad_pkg::REG_COLOR, 16'(c));
		write_reg(vad_pkg::REG_TEX, 16'(t));
		write_reg(vad_pkg::REG_NORMAL, 16'(n));
		write_reg(vad_pkg::REG_POS, 16'(p));
	endtask

	// offer one item and hold it until accepted
	task automatic send_vertex(input vad_pkg::vin_t v);
		vin.valid <= 1'b1;
		vin.data <= v;
		@(posedge clk);
		while (!vin.ready) @(posedge clk);
		pending_vertices.push_back(decode_vertex(v));
	endtask

	task automatic pause_sender(input int n);
		vin.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain_outputs();
		vin.valid <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			2: return {$urandom_range(0, 1) ? 9'h0ff : 9'h1ff, 23'($urandom)};
			3: return 32'($urandom_range(0, 65535));
			default: return $urandom;
		endcase
	endfunction

	function automatic vad_pkg::vin_t random_vertex(input bit starts_batch);
		vad_pkg::vin_t v;
		v.first_of_batch = starts_batch;
		v.raw_color = random_word();
		v.raw_u = random_word();
		v.raw_v = random_word();
		v.raw_nx = $urandom;
		v.raw_ny = $urandom;
		v.raw_nz = $urandom;
		v.raw_px = random_word();
		v.raw_py = random_word();
		v.raw_pz = random_word();
		if ($urandom_range(0, 3) == 0) v.raw_color[31:24] = 8'hff;
		if ($urandom_range(0, 3) == 0) v.raw_color[15:12] = 4'hf;
		return v;
	endfunction

	// directed table: formats, one vertex, known result where plain to read
	typedef struct {
		logic [2:0] col;
		logic [2:0] tex;
		logic [1:0] nrm;
		logic [2:0] pos;
		vad_pkg::vin_t v;
		bit known;
		vad_pkg::vout_t want;
	} directed_row_t;

	directed_row_t directed_rows[$];

	function automatic vad_pkg::vin_t fill_vertex(input logic fb, input logic [31:0] c,
			input logic [31:0] u, input logic [31:0] w, input logic [31:0] n,
			input logic [31:0] p, input logic [31:0] z);
		vad_pkg::vin_t v;
		v = '{fb, c, u, w, n, ~n, n ^ 32'h5a5a5a5a, p, ~p, z};
		return v;
	endfunction

	task automatic add_row(input logic [2:0] c, input logic [2:0] t,
			input logic [1:0] n, input logic [2:0] p, input vad_pkg::vin_t v,
			input bit known, input vad_pkg::vout_t want);
		directed_row_t r;
		r = '{c, t, n, p, v, known, want};
		directed_rows.push_back(r);
	endtask

	task automatic build_directed();
		vad_pkg::vout_t w;
		// after reset: float positions pass, bounds at reset values
		w = '0;
		w.pos_x = 32'h3f800000; w.pos_y = ~32'h3f800000; w.pos_z = 32'h7fc00000;
		w.all_alpha_full = 1'b1;
		w.uv_bounds = {16'h0000, 16'hffff, 16'h0000, 16'hffff};
		add_row(vad_pkg::COL_NONE, vad_pkg::TEX_NONE, vad_pkg::NRM_NONE, vad_pkg::POS_FLT,
			fill_vertex(1'b0, 32'hdeadbeef, 32'h1, 32'h2, 32'h0, 32'h3f800000,
				32'h7fc00000), 1'b1, w);
		// each color format with an all-ones and an all-zero color: both alpha outcomes where the format has alpha
		for (int c = 1; c <= 4; c++) begin
			add_row(3'(c), vad_pkg::TEX_NONE, vad_pkg::NRM_NONE, vad_pkg::POS_FLT,
				fill_vertex(1'b1, 32'hffffffff, 0, 0, 0, 0, 0), 1'b0, '0);
			add_row(3'(c), vad_pkg::TEX_NONE, vad_pkg::NRM_NONE, vad_pkg::POS_FLT,
				fill_vertex(1'b0, 32'h00000000, 0, 0, 0, 0, 0), 1'b0, '0);
		end
		add_row(3'd7, vad_pkg::TEX_NONE, vad_pkg::NRM_NONE, vad_pkg::POS_FLT,
			fill_vertex(1'b0, 32'h12345678, 0, 0, 0, 0, 0), 1'b0, '0);
		// texcoord formats at extremes, bounds in u16 through
		for (int t = 1; t <= 7; t++)
			add_row(vad_pkg::COL_NONE, 3'(t), vad_pkg::NRM_NONE, vad_pkg::POS_FLT,
				fill_vertex(t == 4, 32'h0, 32'hffffffff, 32'h00000000, 0, 0, 0),
				1'b0, '0);
		// normals at every width
		for (int n = 1; n <= 3; n++)
			add_row(vad_pkg::COL_NONE, vad_pkg::TEX_NONE, 2'(n), vad_pkg::POS_FLT,
				fill_vertex(1'b0, 0, 0, 0, 32'h8080ff7f, 0, 0), 1'b0, '0);
		// positions: signed extremes, unknown format, z clamp cases
		for (int p = 0; p <= 7; p++)
			add_row(vad_pkg::COL_NONE, vad_pkg::TEX_NONE, vad_pkg::NRM_NONE, 3'(p),
				fill_vertex(1'b0, 0, 0, 0, 0, 32'h00008080, 32'h0000ff80), 1'b0, '0);
		add_row(vad_pkg::COL_NONE, vad_pkg::TEX_NONE, vad_pkg::NRM_NONE, vad_pkg::POS_FLTT,
			fill_vertex(1'b0, 0, 0, 0, 0, 32'h0, 32'h80000000), 1'b0, '0);
		add_row(vad_pkg::COL_NONE, vad_pkg::TEX_NONE, vad_pkg::NRM_NONE, vad_pkg::POS_FLTT,
			fill_vertex(1'b0, 0, 0, 0, 0, 32'h0, 32'h7f800000), 1'b0, '0);
		add_row(vad_pkg::COL_NONE, vad_pkg::TEX_NONE, vad_pkg::NRM_NONE, vad_pkg::POS_FLTT,
			fill_vertex(1'b0, 0, 0, 0, 0, 32'h0, 32'h47800000), 1'b0, '0);
	endtask

	// directed part then random phases
	initial begin
		vad_pkg::vin_t v;
		int sent;
		int burst;
		vin.valid = 1'b0;
		vin.data = '0;
		shadow_cfg = '{vad_pkg::COL_NONE, vad_pkg::TEX_NONE, vad_pkg::NRM_NONE,
			vad_pkg::POS_FLT, 16'hffff, 16'h0, 16'hffff, 16'h0};
		alpha_full = 1'b1;
		lo_u = 16'hffff; hi_u = 16'h0; lo_v = 16'hffff; hi_v = 16'h0;
		build_directed();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first row runs on reset settings without writes
		foreach (directed_rows[i]) begin
			if (i != 0) begin
				drain_outputs();
				write_formats(directed_rows[i].col, directed_rows[i].tex,
					directed_rows[i].nrm, directed_rows[i].pos);
			end
			if (directed_rows[i].known) begin
				void'(decode_vertex(directed_rows[i].v));
				pending_vertices.push_back(directed_rows[i].want);
				vin.valid <= 1'b1;
				vin.data <= directed_rows[i].v;
				@(posedge clk);
				while (!vin.ready) @(posedge clk);
			end else begin
				send_vertex(directed_rows[i].v);
			end
		end

		// random phases, bound registers at extremes and random
		sent = 0;
		for (int phase = 0; sent < RandomItems; phase++) begin
			drain_outputs();
			write_formats(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
				2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
			if ($urandom_range(0, 3) == 0) write_reg(vad_pkg::REG_TEX, 16'(vad_pkg::TEX_U16T));
			case (phase % 3)
				0: begin
					write_reg(vad_pkg::REG_MIN_U, 16'hffff);
					write_reg(vad_pkg::REG_MAX_U, 16'h0);
					write_reg(vad_pkg::REG_MIN_V, 16'hffff);
					write_reg(vad_pkg::REG_MAX_V, 16'h0);
				end
				1: begin
					write_reg(vad_pkg::REG_MIN_U, 16'h0);
					write_reg(vad_pkg::REG_MAX_U, 16'hffff);
					write_reg(vad_pkg::REG_MIN_V, 16'h0);
					write_reg(vad_pkg::REG_MAX_V, 16'hffff);
				end
				default: begin
					write_reg(vad_pkg::REG_MIN_U, 16'($urandom));
					write_reg(vad_pkg::REG_MAX_U, 16'($urandom));
					write_reg(vad_pkg::REG_MIN_V, 16'($urandom));
					write_reg(vad_pkg::REG_MAX_V, 16'($urandom));
				end
			endcase
			// long receiver hold-off starts while this phase is sending
			if (phase == 2) hold_go = 1'b1;
			for (int k = 0; k < 120 && sent < RandomItems; ) begin
				burst = $urandom_range(1, 24);
				for (int b = 0; b < burst && k < 120; b++) begin
					v = random_vertex(k == 0 || $urandom_range(0, 15) == 0);
					send_vertex(v);
					k++;
					sent++;
				end
				if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
			end
		end
		drain_outputs();
		repeat (10) @(posedge clk);
		if (mismatches == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

	// long hold-off, counted in its own cycles
	initial begin
		wait (hold_go);
		repeat (2) @(posedge clk);
		hold_sink <= 1'b1;
		repeat (80) @(posedge clk);
		hold_sink <= 1'b0;
	end

	// receiver stall pattern, forced low during the hold-off
	initial begin
		int mode;
		vout.ready = 1'b0;
		wait (arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(5, 40)) begin
				@(posedge clk);
				if (hold_sink) vout.ready <= 1'b0;
				else if (mode == 0) vout.ready <= 1'b1;
				else if (mode == 1) vout.ready <= ($urandom_range(0, 3) != 0);
				else vout.ready <= 1'($urandom_range(0, 1));
			end
		end
	end

	// result checking against the oldest expected vertex
	always @(posedge clk) begin
		vad_pkg::vout_t want;
		if (arst_n && vout.valid && vout.ready) begin
			if (pending_vertices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected vertex %h", vout.data);
			end else begin
				want = pending_vertices.pop_front();
				if (vout.data !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("vertex mismatch\n  expected %h\n  actual   %h",
							want, vout.data);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit && !timed_out) begin
			timed_out = 1'b1;
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule
`default_nettype wire
